[sv/slxfr_pkg.sv]
package slxfr_pkg;

	localparam logic [7:0]  SYNC_BYTE       = 8'hAA;
	localparam logic [7:0]  MAX_LEN_RESET   = 8'd255;
	localparam logic [23:0] TIMEOUT_RESET   = 24'd2000000;
	localparam logic [7:0]  MIN_FRAME_LEN   = 8'd2;

	// Configuration register indexes.
	localparam logic CFG_MAX_FRAME_LEN = 1'b0;
	localparam logic CFG_BYTE_TIMEOUT  = 1'b1;

	// Input command codes.
	localparam logic CMD_BYTE = 1'b0;
	localparam logic CMD_TICK = 1'b1;

	// Result kinds.
	localparam logic KIND_PAYLOAD = 1'b0;
	localparam logic KIND_END     = 1'b1;

	// End-of-frame status codes.
	localparam logic [2:0] ST_OK          = 3'd0;
	localparam logic [2:0] ST_LEN_TIMEOUT = 3'd1;
	localparam logic [2:0] ST_BAD_LEN     = 3'd2;
	localparam logic [2:0] ST_PAY_TIMEOUT = 3'd3;
	localparam logic [2:0] ST_CHECKSUM    = 3'd4;

	typedef enum logic [2:0] {
		PH_IDLE    = 3'b001,
		PH_LEN     = 3'b010,
		PH_PAYLOAD = 3'b100
	} phase_t;

	typedef struct packed {
		logic       valid;
		logic       kind;
		logic [7:0] payload_byte;
		logic [2:0] status;
		logic [7:0] payload_len;
	} result_t;

endpackage

[sv/slxfr_core.sv]
module slxfr_core import slxfr_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        step,
	input  logic        cmd,
	input  logic [7:0]  rx_byte,
	input  logic [7:0]  max_frame_len,
	input  logic [23:0] byte_timeout,
	output result_t     result
);

	phase_t      phase_q, phase_d;
	logic [7:0]  frame_len_q, frame_len_d;
	logic [7:0]  byte_count_q, byte_count_d;
	logic [7:0]  xor_q, xor_d;
	logic [23:0] tick_q, tick_d;
	logic [24:0] tick_inc;
	logic        timed_out;
	logic [8:0]  count_inc;

	assign tick_inc  = {1'b0, tick_q} + 25'd1;
	assign timed_out = tick_inc >= {1'b0, byte_timeout};
	assign count_inc = {1'b0, byte_count_q} + 9'd1;

	always_comb begin
		phase_d      = phase_q;
		frame_len_d  = frame_len_q;
		byte_count_d = byte_count_q;
		xor_d        = xor_q;
		tick_d       = tick_q;
		result       = '0;
		if (cmd == CMD_TICK) begin
			if (phase_q == PH_LEN || phase_q == PH_PAYLOAD) begin
				if (timed_out) begin
					// Abort the frame and report which byte was overdue.
					phase_d      = PH_IDLE;
					frame_len_d  = '0;
					byte_count_d = '0;
					xor_d        = '0;
					tick_d       = '0;
					result.valid = 1'b1;
					result.kind  = KIND_END;
					result.status = (phase_q == PH_LEN) ? ST_LEN_TIMEOUT : ST_PAY_TIMEOUT;
				end else begin
					tick_d = tick_inc[23:0];
				end
			end else begin
				phase_d = PH_IDLE;
			end
		end else begin
			tick_d = '0;
			unique case (phase_q)
				PH_LEN: begin
					if (rx_byte < MIN_FRAME_LEN || rx_byte > max_frame_len) begin
						phase_d       = PH_IDLE;
						frame_len_d   = '0;
						byte_count_d  = '0;
						xor_d         = '0;
						result.valid  = 1'b1;
						result.kind   = KIND_END;
						result.status = ST_BAD_LEN;
					end else begin
						phase_d      = PH_PAYLOAD;
						frame_len_d  = rx_byte;
						byte_count_d = '0;
						xor_d        = '0;
					end
				end
				PH_PAYLOAD: begin
					if (count_inc < {1'b0, frame_len_q}) begin
						xor_d               = xor_q ^ rx_byte;
						byte_count_d        = count_inc[7:0];
						result.valid        = 1'b1;
						result.kind         = KIND_PAYLOAD;
						result.payload_byte = rx_byte;
					end else begin
						// Last byte is the checksum.
						phase_d      = PH_IDLE;
						frame_len_d  = '0;
						byte_count_d = '0;
						xor_d        = '0;
						result.valid = 1'b1;
						result.kind  = KIND_END;
						if (rx_byte == xor_q) begin
							result.status      = ST_OK;
							result.payload_len = frame_len_q - 8'd1;
						end else begin
							result.status = ST_CHECKSUM;
						end
					end
				end
				default: begin
					phase_d = PH_IDLE;
					if (rx_byte == SYNC_BYTE) begin
						phase_d      = PH_LEN;
						frame_len_d  = '0;
						byte_count_d = '0;
						xor_d        = '0;
					end
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= PH_IDLE;
			frame_len_q  <= '0;
			byte_count_q <= '0;
			xor_q        <= '0;
			tick_q       <= '0;
		end else if (step) begin
			phase_q      <= phase_d;
			frame_len_q  <= frame_len_d;
			byte_count_q <= byte_count_d;
			xor_q        <= xor_d;
			tick_q       <= tick_d;
		end
	end

endmodule

[sv/sync_length_xor_frame_receiver.sv]
// Frame receiver for a sync/length/XOR-checksum serial protocol. Each input
// transaction is either a received byte (cmd 0) or one elapsed poll tick
// (cmd 1). In idle the block drops bytes until it sees the sync byte 0xAA;
// the next byte is the frame length (payload plus checksum), which must lie
// between 2 and max_frame_len. Payload bytes are forwarded one output
// transaction each (kind 0) as they arrive, and the final byte is checked
// against the XOR of the payload. The frame ends with one kind 1 transaction
// whose status is ok (with payload_len), length timeout, bad length, payload
// timeout or checksum error. While a frame is open, ticks count the time
// since the last byte and a frame is aborted when that count reaches
// byte_timeout; ticks in idle are ignored. A transaction is taken into an
// input register and then processed into an output register, and one
// transaction is accepted every cycle as long as the output side keeps
// taking results. Configuration is written through cfg_we/cfg_index/
// cfg_wdata and should only change while no frame is in flight.
module sync_length_xor_frame_receiver import slxfr_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	// Configuration write port.
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [23:0] cfg_wdata,
	// Input channel.
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        cmd,
	input  logic [7:0]  rx_byte,
	// Output channel.
	output logic        out_valid,
	input  logic        out_ready,
	output logic        kind,
	output logic [7:0]  payload_byte,
	output logic [2:0]  status,
	output logic [7:0]  payload_len
);

	logic [7:0]  max_frame_len_q;
	logic [23:0] byte_timeout_q;

	logic       valid_s1;
	logic       cmd_s1;
	logic [7:0] rx_byte_s1;

	logic       out_valid_q;
	logic       kind_q;
	logic [7:0] payload_byte_q;
	logic [2:0] status_q;
	logic [7:0] payload_len_q;

	logic    advance;
	result_t res;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_frame_len_q <= MAX_LEN_RESET;
			byte_timeout_q  <= TIMEOUT_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_MAX_FRAME_LEN: max_frame_len_q <= cfg_wdata[7:0];
				CFG_BYTE_TIMEOUT:  byte_timeout_q  <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// The held transaction moves on whenever the result register is free or
	// is being emptied in this cycle; that also frees the input register.
	assign advance  = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			cmd_s1     <= cmd;
			rx_byte_s1 <= rx_byte;
		end
	end

	slxfr_core u_core (
		.clk           (clk),
		.arst_n        (arst_n),
		.step          (advance),
		.cmd           (cmd_s1),
		.rx_byte       (rx_byte_s1),
		.max_frame_len (max_frame_len_q),
		.byte_timeout  (byte_timeout_q),
		.result        (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= res.valid;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && res.valid) begin
			kind_q         <= res.kind;
			payload_byte_q <= res.payload_byte;
			status_q       <= res.status;
			payload_len_q  <= res.payload_len;
		end
	end

	assign out_valid    = out_valid_q;
	assign kind         = kind_q;
	assign payload_byte = payload_byte_q;
	assign status       = status_q;
	assign payload_len  = payload_len_q;

endmodule
